// ----- sv/bwsu_pkg.sv -----
`default_nettype none

package bwsu_pkg;

  typedef struct packed {
    logic [5:0]  bit_length;
    logic [5:0]  max_ones;
    logic [32:0] rank;
  } query_t;

  typedef struct packed {
    logic [31:0] word;
    logic        found;
  } result_t;

  localparam int RankW = 33;
  localparam int LenW  = 6;
  localparam int WordW = 32;

  // Number of m-bit words with at most k ones, k saturating at m.
  function automatic logic [63:0] count_at_most(input int m, input int k);
    logic [63:0] row [0:63];
    logic [63:0] sum;
    int          kk;
    for (int j = 0; j < 64; j++) begin
      row[j] = 64'd0;
    end
    row[0] = 64'd1;
    for (int i = 1; i <= m; i++) begin
      for (int j = i; j >= 1; j--) begin
        row[j] = row[j] + row[j-1];
      end
    end
    kk  = (k > m) ? m : k;
    sum = 64'd0;
    for (int j = 0; j <= kk; j++) begin
      sum = sum + row[j];
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

// ----- sv/bwsu_cell.sv -----
`default_nettype none

module bwsu_cell #(
  parameter int MAX_BITS = 32,
  parameter int POS      = 0
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  input  wire logic [bwsu_pkg::LenW-1:0]         in_n,
  input  wire logic [$clog2(MAX_BITS+1)-1:0]     in_ones,
  input  wire logic [bwsu_pkg::RankW-1:0]        in_rank,
  input  wire logic [MAX_BITS-1:0]               in_word,
  output logic                                   out_valid,
  output logic [bwsu_pkg::LenW-1:0]              out_n,
  output logic [$clog2(MAX_BITS+1)-1:0]          out_ones,
  output logic [bwsu_pkg::RankW-1:0]             out_rank,
  output logic [MAX_BITS-1:0]                    out_word
);

  localparam int CntW = MAX_BITS + 1;
  localparam int KW   = $clog2(MAX_BITS + 1);
  localparam int CmpW = (CntW > bwsu_pkg::RankW) ? CntW : bwsu_pkg::RankW;

  // Counts of POS-bit words holding at most k ones, for every k.
  logic [CntW-1:0] tab [0:MAX_BITS];

  for (genvar k = 0; k <= MAX_BITS; k++) begin : g_tab
    localparam logic [63:0] Val = bwsu_pkg::count_at_most(POS, k);
    assign tab[k] = Val[CntW-1:0];
  end

  logic [CntW-1:0]                  zeros_first;
  logic                             take_one;
  logic [KW-1:0]                    ones_next;
  logic [bwsu_pkg::RankW-1:0]       rank_next;
  logic [MAX_BITS-1:0]              word_next;
  logic [CmpW-1:0]                  diff;

  always_comb begin
    zeros_first = tab[in_ones];
    take_one    = (in_n > bwsu_pkg::LenW'(POS)) && (in_ones != '0) &&
                  (CmpW'(in_rank) > CmpW'(zeros_first));
    diff        = CmpW'(in_rank) - CmpW'(zeros_first);
    ones_next   = in_ones;
    rank_next   = in_rank;
    word_next   = in_word;
    if (take_one) begin
      ones_next      = in_ones - KW'(1);
      rank_next      = diff[bwsu_pkg::RankW-1:0];
      word_next[POS] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_n    <= in_n;
    out_ones <= ones_next;
    out_rank <= rank_next;
    out_word <= word_next;
  end

endmodule

`default_nettype wire

// ----- sv/bounded_weight_string_unrank.sv -----
// An accepted start passes through every cell of the chain and the final stage before the done strobe.
// Throughput: one query per cycle; each cell of the chain decodes one bit
// position, most significant first, and the final stage forms the result.
// busy is high only during reset, and the receiver cannot stall the result.
// Synchronous active-high reset clears the valid bits of the chain.
`default_nettype none

module bounded_weight_string_unrank #(
  parameter int MAX_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire bwsu_pkg::query_t  query,
  output logic                   done,
  output bwsu_pkg::result_t      result
);

  localparam int KW   = $clog2(MAX_BITS + 1);
  localparam int OutW = (MAX_BITS > bwsu_pkg::WordW) ? MAX_BITS : bwsu_pkg::WordW;

  logic                        v    [0:MAX_BITS];
  logic [bwsu_pkg::LenW-1:0]   n    [0:MAX_BITS];
  logic [KW-1:0]               ones [0:MAX_BITS];
  logic [bwsu_pkg::RankW-1:0]  rnk  [0:MAX_BITS];
  logic [MAX_BITS-1:0]         wrd  [0:MAX_BITS];

  assign busy = rst;

  // The ones bound saturates at the table size without changing any count.
  always_comb begin
    v[0]    = start & ~busy;
    n[0]    = query.bit_length;
    rnk[0]  = query.rank;
    wrd[0]  = '0;
    if (query.max_ones > bwsu_pkg::LenW'(MAX_BITS)) begin
      ones[0] = KW'(MAX_BITS);
    end else begin
      ones[0] = KW'(query.max_ones);
    end
  end

  for (genvar i = 0; i < MAX_BITS; i++) begin : g_cell
    bwsu_cell #(
      .MAX_BITS (MAX_BITS),
      .POS      (MAX_BITS - 1 - i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[i]),
      .in_n      (n[i]),
      .in_ones   (ones[i]),
      .in_rank   (rnk[i]),
      .in_word   (wrd[i]),
      .out_valid (v[i+1]),
      .out_n     (n[i+1]),
      .out_ones  (ones[i+1]),
      .out_rank  (rnk[i+1]),
      .out_word  (wrd[i+1])
    );
  end

  // A rank inside the count always decodes down to one remaining word.
  logic            found_next;
  logic [OutW-1:0] word_ext;

  always_comb begin
    found_next = (n[MAX_BITS] != '0) &&
                 (n[MAX_BITS] <= bwsu_pkg::LenW'(MAX_BITS)) &&
                 (rnk[MAX_BITS] == bwsu_pkg::RankW'(1));
    word_ext   = OutW'(wrd[MAX_BITS]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v[MAX_BITS];
    end
  end

  always_ff @(posedge clk) begin
    result.found <= found_next;
    result.word  <= found_next ? word_ext[bwsu_pkg::WordW-1:0] : '0;
  end

endmodule

`default_nettype wire
